### sv/twvm_pkg.sv
// ----------------------------------------------------------------------------
// twvm_pkg
// Shared types and constants for the time-window velocity mean block.
// ----------------------------------------------------------------------------
package twvm_pkg;

    localparam int unsigned TimeWidth = 48;
    localparam int unsigned VelWidth  = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_EVICT_SUB,
        ST_APPEND_CHK,
        ST_FULL_RD,
        ST_FULL_SUB,
        ST_WRITE,
        ST_DIV,
        ST_OUT
    } state_t;

    // start request and lane select from sequencer to divider
    typedef struct packed {
        logic       start;
        logic [1:0] lane;
    } div_req_t;

endpackage

### sv/twvm_div.sv
// ----------------------------------------------------------------------------
// twvm_div
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module twvm_div #(
    parameter int unsigned SumWidth = 39,
    parameter int unsigned CntWidth = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SumWidth-1:0] dividend,
    input  logic [CntWidth-1:0]        divisor,
    output logic                       done,
    output logic signed [SumWidth-1:0] quotient
);

    localparam int unsigned StepWidth = $clog2(SumWidth + 1);

    logic [SumWidth-1:0]  quo_reg, quo_next;
    logic [SumWidth:0]    rem_reg, rem_next;
    logic [StepWidth-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;
    logic [SumWidth:0]    trial;
    logic [SumWidth:0]    shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[SumWidth-1:0], quo_reg[SumWidth-1]};
        trial     = shifted - {{(SumWidth+1-CntWidth){1'b0}}, divisor};
        if (start)
        begin
            neg_next  = dividend[SumWidth-1];
            quo_next  = dividend[SumWidth-1] ? SumWidth'(-dividend) : SumWidth'(dividend);
            rem_next  = '0;
            step_next = StepWidth'(SumWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SumWidth])
            begin
                rem_next = trial;
                quo_next = {quo_reg[SumWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[SumWidth-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("divider restarted while busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");

endmodule

### sv/time_window_velocity_mean.sv
// ----------------------------------------------------------------------------
// time_window_velocity_mean
// Moving mean of odometry velocities over a time window.
// ----------------------------------------------------------------------------
// One reading is taken at a time. Each evicted entry is read, checked and
// subtracted, the reading is appended if fresh and in order, then unless the
// buffer is empty the three running sums are divided by the entry count on
// one shared bit-serial divider before the result register is loaded. The
// input is not ready again until that result has been taken.
// The buffer sits in one memory with a single read and write port; no
// clearing pass is needed after reset.
module time_window_velocity_mean #(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // current_time[47:0], sample_time[95:48], pos_x[127:96], pos_y[159:128],
    // heading[175:160], vel_linear[207:176], vel_lateral[239:208],
    // vel_angular[271:240]
    input  logic [271:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_time[47:0], out_pos_x[79:48], out_pos_y[111:80], out_heading[127:112],
    // mean_linear[159:128], mean_lateral[191:160], mean_angular[223:192]
    output logic [223:0] m_tdata,
    // passed_through[0], entries_used[7:1]
    output logic [7:0]   m_tuser
);

    localparam int unsigned IdxWidth = $clog2(BUFFER_DEPTH);
    localparam int unsigned CntWidth = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned SumWidth = 32 + CntWidth;
    localparam int unsigned TW = twvm_pkg::TimeWidth;
    localparam int unsigned EntWidth = TW + 3 * twvm_pkg::VelWidth;

    twvm_pkg::state_t state_reg, state_next;

    logic [31:0]           win_reg;
    logic [271:0]          in_reg;
    logic [IdxWidth-1:0]   oldest_reg, oldest_next;
    logic [CntWidth-1:0]   count_reg, count_next;
    logic signed [SumWidth-1:0] sum_reg [3];
    logic signed [SumWidth-1:0] sum_next [3];
    logic [TW-1:0]         newest_stamp_reg, newest_stamp_next;
    logic [79:0]           pose_reg;
    logic [1:0]            lane_reg, lane_next;
    logic signed [31:0]    mean_reg [3];
    logic [223:0]          out_data_reg;
    logic [7:0]            out_user_reg;
    logic                  out_valid_reg;

    logic [EntWidth-1:0]   mem [BUFFER_DEPTH];
    logic [EntWidth-1:0]   rd_data_reg;
    logic [IdxWidth-1:0]   rd_addr;
    logic                  wr_en;
    logic [IdxWidth-1:0]   wr_addr;
    logic [CntWidth:0]     wr_sum;

    logic [TW-1:0]         now, stamp;
    logic signed [TW:0]    age_old, age_new;
    logic                  accept;
    logic                  fresh, ordered, take;
    twvm_pkg::div_req_t    div_req;
    logic                  div_done;
    logic signed [SumWidth-1:0] div_q;

    assign now    = in_reg[47:0];
    assign stamp  = in_reg[95:48];
    assign accept = s_tvalid && s_tready;

    assign s_tready  = (state_reg == twvm_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;

    assign age_old = $signed({1'b0, now}) - $signed({1'b0, rd_data_reg[TW-1:0]});
    assign age_new = $signed({1'b0, now}) - $signed({1'b0, stamp});
    assign fresh   = age_new < $signed({{(TW-32){1'b0}}, 1'b0, win_reg});
    assign ordered = (count_reg == '0) || (newest_stamp_reg < stamp);
    assign take    = fresh && ordered;
    // oldest + count wraps at most once past the end of the buffer
    assign wr_sum  = (CntWidth+1)'(oldest_reg) + (CntWidth+1)'(count_reg);
    assign wr_addr = (wr_sum >= (CntWidth+1)'(BUFFER_DEPTH))
                     ? IdxWidth'(wr_sum - (CntWidth+1)'(BUFFER_DEPTH))
                     : IdxWidth'(wr_sum);
    assign rd_addr = oldest_reg;
    assign wr_en   = (state_reg == twvm_pkg::ST_WRITE) && take;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {in_reg[271:176], stamp};
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            twvm_pkg::ST_IDLE:
                if (accept)
                    state_next = twvm_pkg::ST_EVICT_RD;
            twvm_pkg::ST_EVICT_RD:
                state_next = (count_reg == '0) ? twvm_pkg::ST_APPEND_CHK
                                               : twvm_pkg::ST_EVICT_CHK;
            twvm_pkg::ST_EVICT_CHK:
                state_next = (age_old > $signed({{(TW-32){1'b0}}, 1'b0, win_reg}))
                             ? twvm_pkg::ST_EVICT_SUB : twvm_pkg::ST_APPEND_CHK;
            twvm_pkg::ST_EVICT_SUB:
                state_next = twvm_pkg::ST_EVICT_RD;
            twvm_pkg::ST_APPEND_CHK:
                state_next = (take && count_reg == CntWidth'(BUFFER_DEPTH))
                             ? twvm_pkg::ST_FULL_RD : twvm_pkg::ST_WRITE;
            twvm_pkg::ST_FULL_RD:
                state_next = twvm_pkg::ST_FULL_SUB;
            twvm_pkg::ST_FULL_SUB:
                state_next = twvm_pkg::ST_WRITE;
            twvm_pkg::ST_WRITE:
                state_next = twvm_pkg::ST_DIV;
            twvm_pkg::ST_DIV:
                if (count_reg == '0 || (div_done && lane_reg == 2'd2))
                    state_next = twvm_pkg::ST_OUT;
            twvm_pkg::ST_OUT:
                state_next = twvm_pkg::ST_IDLE;
            default:
                state_next = twvm_pkg::ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        oldest_next       = oldest_reg;
        count_next        = count_reg;
        newest_stamp_next = newest_stamp_reg;
        lane_next         = lane_reg;
        div_req.start     = 1'b0;
        div_req.lane      = lane_reg;
        for (int i = 0; i < 3; i++)
            sum_next[i] = sum_reg[i];
        unique case (state_reg)
            twvm_pkg::ST_EVICT_SUB, twvm_pkg::ST_FULL_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    sum_next[i] = sum_reg[i]
                        - SumWidth'($signed(rd_data_reg[TW+32*i +: 32]));
                oldest_next = (oldest_reg == IdxWidth'(BUFFER_DEPTH - 1))
                              ? '0 : oldest_reg + 1'b1;
                count_next  = count_reg - 1'b1;
            end
            twvm_pkg::ST_WRITE:
            begin
                if (take)
                begin
                    for (int i = 0; i < 3; i++)
                        sum_next[i] = sum_reg[i]
                            + SumWidth'($signed(in_reg[176+32*i +: 32]));
                    count_next        = count_reg + 1'b1;
                    newest_stamp_next = stamp;
                end
                lane_next = 2'd0;
            end
            twvm_pkg::ST_DIV:
            begin
                if (div_done)
                    lane_next = lane_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        // kick the divider on entry to the divide phase, unless the buffer is empty, and after each lane but the last
        if ((state_reg == twvm_pkg::ST_WRITE && (take || count_reg != '0))
            || (state_reg == twvm_pkg::ST_DIV && div_done && lane_reg != 2'd2))
            div_req.start = 1'b1;
        div_req.lane = lane_next;
    end

    twvm_div #(
        .SumWidth(SumWidth),
        .CntWidth(CntWidth)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_req.start),
        .dividend(sum_next[div_req.lane]),
        .divisor (count_next),
        .done    (div_done),
        .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= twvm_pkg::ST_IDLE;
            win_reg          <= 32'd500000;
            oldest_reg       <= '0;
            count_reg        <= '0;
            newest_stamp_reg <= '0;
            lane_reg         <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            oldest_reg       <= oldest_next;
            count_reg        <= count_next;
            newest_stamp_reg <= newest_stamp_next;
            lane_reg         <= lane_next;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= sum_next[i];
            if (cfg_valid && cfg_ready)
                win_reg <= cfg_data;
            if (state_reg == twvm_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= s_tdata;
        if (state_reg == twvm_pkg::ST_WRITE && take)
            pose_reg <= in_reg[175:96];
        if (div_done)
            mean_reg[lane_reg] <= div_q[31:0];
        if (state_reg == twvm_pkg::ST_OUT)
        begin
            if (count_reg == '0)
            begin
                out_data_reg <= {in_reg[271:176], in_reg[175:48]};
                out_user_reg <= 8'd1;
            end
            else
            begin
                out_data_reg <= {mean_reg[2], mean_reg[1], mean_reg[0],
                                 pose_reg, newest_stamp_reg};
                out_user_reg <= {7'(count_reg), 1'b0};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntWidth'(BUFFER_DEPTH)) else $error("entry count overflow");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != twvm_pkg::ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == twvm_pkg::ST_OUT))
        else $error("result without item");

endmodule

### tb/tb_time_window_velocity_mean.sv
// ----------------------------------------------------------------------------
// tb_time_window_velocity_mean
// Self-checking bench: readings are streamed in under random stalls, each
// result beat is checked against a local model of the windowed mean.
// ----------------------------------------------------------------------------
module tb_time_window_velocity_mean;

    localparam int Depth = 64;

    typedef struct packed {
        logic [31:0] vel_angular;
        logic [31:0] vel_lateral;
        logic [31:0] vel_linear;
        logic [15:0] heading;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic [47:0] sample_time;
        logic [47:0] current_time;
    } reading_t;

    typedef struct packed {
        logic [6:0]  entries_used;
        logic        passed_through;
        logic [31:0] mean_angular;
        logic [31:0] mean_lateral;
        logic [31:0] mean_linear;
        logic [15:0] out_heading;
        logic [31:0] out_pos_y;
        logic [31:0] out_pos_x;
        logic [47:0] out_time;
    } mean_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [271:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;
    logic [7:0]   m_tuser;

    time_window_velocity_mean #(.BUFFER_DEPTH(Depth)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // model state
    logic [47:0]        win_stamp [Depth];
    logic signed [63:0] win_vel   [Depth][3];
    int                 win_head;
    int                 win_count;
    logic signed [63:0] vel_sum [3];
    logic [31:0]        last_x, last_y;
    logic [15:0]        last_hd;
    logic [31:0]        window_us;
    logic [47:0]        stream_now;

    reading_t pending_q [$];
    mean_t    mean_q [$];
    int       errors;
    int       send_idle, recv_idle;
    logic     hold_arm;
    logic     hold_on;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task automatic drop_oldest();
        for (int k = 0; k < 3; k++)
            vel_sum[k] -= win_vel[win_head][k];
        win_head = (win_head + 1) % Depth;
        win_count--;
    endtask

    function automatic logic [31:0] mean_of(input logic signed [63:0] s, input int n);
        logic signed [63:0] q;
        q = s / n;
        return q[31:0];
    endfunction

    task automatic predict_mean(input reading_t r);
        logic signed [63:0] now, age;
        logic               fresh, ordered;
        int                 slot, nw;
        mean_t              m;
        now = {16'd0, r.current_time};
        while (win_count > 0 && now - $signed({16'd0, win_stamp[win_head]})
               > $signed({32'd0, window_us}))
            drop_oldest();
        age = now - $signed({16'd0, r.sample_time});
        fresh = age < $signed({32'd0, window_us});
        ordered = 1'b1;
        if (win_count > 0)
            ordered = win_stamp[(win_head + win_count - 1) % Depth] < r.sample_time;
        if (fresh && ordered)
        begin
            if (win_count >= Depth)
                drop_oldest();
            slot = (win_head + win_count) % Depth;
            win_stamp[slot] = r.sample_time;
            win_vel[slot][0] = $signed(r.vel_linear);
            win_vel[slot][1] = $signed(r.vel_lateral);
            win_vel[slot][2] = $signed(r.vel_angular);
            for (int k = 0; k < 3; k++)
                vel_sum[k] += win_vel[slot][k];
            win_count++;
            last_x = r.pos_x;
            last_y = r.pos_y;
            last_hd = r.heading;
        end
        if (win_count == 0)
        begin
            m.out_time = r.sample_time;
            m.out_pos_x = r.pos_x;
            m.out_pos_y = r.pos_y;
            m.out_heading = r.heading;
            m.mean_linear = r.vel_linear;
            m.mean_lateral = r.vel_lateral;
            m.mean_angular = r.vel_angular;
            m.passed_through = 1'b1;
            m.entries_used = 7'd0;
        end
        else
        begin
            nw = (win_head + win_count - 1) % Depth;
            m.out_time = win_stamp[nw];
            m.out_pos_x = last_x;
            m.out_pos_y = last_y;
            m.out_heading = last_hd;
            m.mean_linear = mean_of(vel_sum[0], win_count);
            m.mean_lateral = mean_of(vel_sum[1], win_count);
            m.mean_angular = mean_of(vel_sum[2], win_count);
            m.passed_through = 1'b0;
            m.entries_used = win_count[6:0];
        end
        mean_q = {mean_q, m};
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(65535, 0)), $urandom()};
    endfunction

    function automatic reading_t rand_reading(input logic [47:0] now,
                                              input logic [47:0] stamp);
        reading_t r;
        r.current_time = now;
        r.sample_time = stamp;
        r.pos_x = $urandom();
        r.pos_y = $urandom();
        r.heading = 16'($urandom());
        r.vel_linear = $urandom();
        r.vel_lateral = $urandom();
        r.vel_angular = $urandom();
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_mean(reading_t'(s_tdata));
                pending_q.delete(0);
            end
            if (s_tvalid && !s_tready)
            begin
                // beat held until taken
            end
            else if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_q[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // long receiver stall, armed once
    initial
    begin
        hold_on = 1'b0;
        wait (hold_arm);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_on <= 1'b0;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        mean_t got, want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[7:0], m_tdata};
                if (mean_q.size() == 0)
                    report("unexpected beat", '0, '0);
                else
                begin
                    want = mean_q[0];
                    mean_q.delete(0);
                    if (got.out_time !== want.out_time)
                        report("out_time", got.out_time, want.out_time);
                    if (got.out_pos_x !== want.out_pos_x)
                        report("out_pos_x", got.out_pos_x, want.out_pos_x);
                    if (got.out_pos_y !== want.out_pos_y)
                        report("out_pos_y", got.out_pos_y, want.out_pos_y);
                    if (got.out_heading !== want.out_heading)
                        report("out_heading", got.out_heading, want.out_heading);
                    if (got.mean_linear !== want.mean_linear)
                        report("mean_linear", got.mean_linear, want.mean_linear);
                    if (got.mean_lateral !== want.mean_lateral)
                        report("mean_lateral", got.mean_lateral, want.mean_lateral);
                    if (got.mean_angular !== want.mean_angular)
                        report("mean_angular", got.mean_angular, want.mean_angular);
                    if (got.passed_through !== want.passed_through)
                        report("passed_through", got.passed_through, want.passed_through);
                    if (got.entries_used !== want.entries_used)
                        report("entries_used", got.entries_used, want.entries_used);
                end
            end
            if (hold_on)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99, 0) >= recv_idle);
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_tvalid || mean_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_window(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        window_us = value;
    endtask

    // a phase of well-formed streams: time advancing, stamps mostly at or before now
    task automatic queue_stream(input int count, input int step_max);
        logic [47:0] now, stamp;
        int          pick;
        now = stream_now + (rand48() >> 16);
        for (int i = 0; i < count; i++)
        begin
            now = now + $urandom_range(step_max, 0);
            pick = $urandom_range(9, 0);
            if (pick < 6)
                stamp = now - $urandom_range(step_max, 0);
            else if (pick < 7)
                stamp = now + $urandom_range(step_max, 0);
            else if (pick < 8)
                stamp = now - window_us + $urandom_range(2, 0) - 1;
            else if (pick < 9)
                stamp = rand48() >> 4;
            else
                stamp = now - $urandom_range(step_max * 4, 0);
            pending_q = {pending_q, rand_reading(now, stamp)};
        end
        stream_now = now;
    endtask

    task automatic queue_directed();
        reading_t r;
        // empty buffer pass-through, extremes of every value field
        r = '1;
        r.sample_time = 48'd0;
        pending_q = {pending_q, r};
        r = '0;
        r.current_time = 48'd2000000;
        r.sample_time = 48'd1000;
        r.vel_linear = 32'h8000_0000;
        r.vel_lateral = 32'h7fff_ffff;
        r.vel_angular = 32'hffff_ffff;
        r.pos_x = 32'h8000_0000;
        r.pos_y = 32'h7fff_ffff;
        r.heading = 16'h8000;
        pending_q = {pending_q, r};
        // appended, then equal stamp rejected, then older rejected
        r.sample_time = 48'd1999000;
        pending_q = {pending_q, r};
        r.vel_linear = 32'h7fff_ffff;
        pending_q = {pending_q, r};
        r.sample_time = 48'd1998000;
        pending_q = {pending_q, r};
        // stored entry at age exactly window is not evicted; new reading, just inside, is appended
        r.current_time = 48'd2499000;
        r.sample_time = 48'd1999000 + 48'd1;
        pending_q = {pending_q, r};
        // future stamp
        r.current_time = 48'd2499000;
        r.sample_time = 48'd2600000;
        pending_q = {pending_q, r};
        // past window: evicts
        r.current_time = 48'd3000001;
        r.sample_time = 48'd3000000;
        pending_q = {pending_q, r};
        // fill past depth with same-sign linear and lateral to hit wrap and full buffer
        for (int i = 0; i < Depth + 4; i++)
        begin
            r.current_time = 48'd3000100 + i;
            r.sample_time = 48'd3000050 + i;
            r.vel_linear = 32'h8000_0000;
            r.vel_lateral = 32'h7fff_ffff;
            r.vel_angular = $urandom();
            r.heading = 16'($urandom());
            pending_q = {pending_q, r};
        end
    endtask

    initial
    begin
        errors = 0;
        hold_arm = 1'b0;
        send_idle = 33;
        recv_idle = 83;
        cfg_valid = 1'b0;
        cfg_data = '0;
        window_us = 32'd500000;
        stream_now = 48'h1000_0000_0000;
        win_head = 0;
        win_count = 0;
        last_x = '0;
        last_y = '0;
        last_hd = '0;
        for (int k = 0; k < 3; k++)
            vel_sum[k] = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        wait_drained();

        // receiver stalls long while sender keeps offering
        queue_stream(40, 20000);
        hold_arm = 1'b1;
        wait_drained();

        write_window(32'd0);
        queue_stream(60, 1000);
        wait_drained();

        send_idle = 83;
        recv_idle = 33;
        write_window(32'hffff_ffff);
        queue_stream(300, 1 << 20);
        wait_drained();

        write_window(32'd100);
        queue_stream(250, 40);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        write_window($urandom_range(200000, 1000));
        queue_stream(400, 20000);
        wait_drained();

        write_window($urandom());
        queue_stream(300, 1 << 22);
        wait_drained();

        if (errors == 0)
            $display("time_window_velocity_mean test passed");
        else
            $display("time_window_velocity_mean test failed");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("time_window_velocity_mean test failed");
        $finish;
    end

endmodule
